// ===== design/blde_pkg.sv =====
// ----------------------------------------------------------------------------
// blde_pkg
// Shared types for the bounded list deque engine: action and status codes,
// controller states and the control groups handed to the cells and head unit.
// ----------------------------------------------------------------------------
package blde_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_TAIL = 3'd0,
      ACT_PUSH_HEAD = 3'd1,
      ACT_POP_HEAD  = 3'd2,
      ACT_POP_TAIL  = 3'd3,
      ACT_REMOVE    = 3'd4,
      ACT_PARTITION = 3'd5,
      ACT_DUMP      = 3'd6,
      ACT_NONE      = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_RUN  = 2'd1,
      FSM_DONE = 2'd2
   } fsm_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_ROTATE = 2'd1,
      CELL_SWAP   = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_ctrl_type;

   typedef struct packed {
      action_type action;
      logic       step;
   } head_ctrl_type;

endpackage

// ===== design/blde_cell.sv =====
// ----------------------------------------------------------------------------
// blde_cell
// One storage cell of the list ring. It either holds, takes its right-hand
// neighbour during a rotation step, or exchanges with a neighbour during one
// phase of the even/odd transposition used for partitioning.
// ----------------------------------------------------------------------------
module blde_cell
   import blde_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int CELL_INDEX  = 0
) (
   input  logic                          clock,
   input  cell_ctrl_type                 ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]    count,
   input  logic [VALUE_WIDTH-1:0]        left_data,
   input  logic [VALUE_WIDTH-1:0]        right_data,
   output logic [VALUE_WIDTH-1:0]        data_out
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] IDX_SELF = CW'(CELL_INDEX);
   localparam logic [CW-1:0] IDX_NEXT = CW'(CELL_INDEX + 1);
   localparam logic IDX_LSB = (CELL_INDEX % 2) == 1;
   localparam logic HAS_LEFT = CELL_INDEX > 0;

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;
   logic                   left_pair_on;
   logic                   right_pair_on;

   // A pair of neighbours is compared only when the phase selects it and both
   // members lie inside the list.
   assign left_pair_on  = (IDX_LSB == ctrl.phase) && (IDX_NEXT < count);
   assign right_pair_on = HAS_LEFT && (IDX_LSB != ctrl.phase) && (IDX_SELF < count);

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_ROTATE: begin
            data_in = right_data;
         end
         CELL_SWAP: begin
            // Only an odd word ahead of an even word is exchanged, which keeps
            // both groups in their original order.
            if (left_pair_on && data_ff[0] && !right_data[0]) begin
               data_in = right_data;
            end else if (right_pair_on && left_data[0] && !data_ff[0]) begin
               data_in = left_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== design/blde_head.sv =====
// ----------------------------------------------------------------------------
// blde_head
// Head unit of the ring. During a rotation pass it sees the entries in list
// order at the first two cells and decides what re-enters the ring at the far
// end: inserting, deleting or passing words through. It also captures the
// word a pop returns.
// ----------------------------------------------------------------------------
module blde_head
   import blde_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  head_ctrl_type                 ctrl,
   input  logic [$clog2(DEPTH)-1:0]      step_index,
   input  logic [$clog2(DEPTH+1)-1:0]    count,
   input  logic [VALUE_WIDTH-1:0]        operand,
   input  logic [VALUE_WIDTH-1:0]        cell0_data,
   input  logic [VALUE_WIDTH-1:0]        cell1_data,
   output logic [VALUE_WIDTH-1:0]        feed_data,
   output logic                          delete_now,
   output logic [VALUE_WIDTH-1:0]        capture_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] hold_ff;
   logic                   delete_ff;
   logic [VALUE_WIDTH-1:0] capture_ff;
   logic [VALUE_WIDTH-1:0] capture_in;
   logic [CW-1:0]          pos;
   logic                   first_step;
   logic                   in_list;
   logic                   is_tail;
   logic                   delete_prev;

   assign pos         = CW'(step_index);
   assign first_step  = (step_index == '0);
   assign in_list     = pos < count;
   assign is_tail     = pos == (count - 1'b1);
   assign delete_prev = first_step ? 1'b0 : delete_ff;

   always_comb begin
      delete_now = 1'b0;
      feed_data  = cell0_data;
      capture_in = capture_ff;
      unique case (ctrl.action)
         ACT_PUSH_TAIL: begin
            feed_data = (pos == count) ? operand : cell0_data;
         end
         ACT_PUSH_HEAD: begin
            // Everything slips back by one place through the hold register.
            feed_data = first_step ? operand : hold_ff;
         end
         ACT_POP_HEAD: begin
            delete_now = 1'b1;
            feed_data  = cell1_data;
            if (first_step) begin
               capture_in = cell0_data;
            end
         end
         ACT_POP_TAIL: begin
            if (is_tail) begin
               capture_in = cell0_data;
            end
         end
         ACT_REMOVE: begin
            // Once the first match is seen, each slot takes its successor.
            delete_now = delete_prev || (in_list && (cell0_data == operand));
            feed_data  = delete_now ? cell1_data : cell0_data;
         end
         default: begin
            feed_data = cell0_data;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         hold_ff    <= cell0_data;
         delete_ff  <= delete_now;
         capture_ff <= capture_in;
      end
   end

   assign capture_data = capture_ff;

endmodule

// ===== design/bounded_list_deque_engine_top.sv =====
// Push, pop, remove and partition make a full pass of the ring, then register the
// result from the done state; refused and empty-list actions go straight there.
// Dump sends one entry beat per cycle during its pass, slowed by stall, and
// answers from the pass itself. The single rotating ring serves one action at a
// time: req_stall holds new requests until the controller is idle again.
// Reset empties the list and the controller; stored words are not cleared.
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_top
// Deque of signed words held in a ring of cells, with push and pop at both
// ends, remove by value, stable even/odd partition and an ordered dump.
// ----------------------------------------------------------------------------
module bounded_list_deque_engine_top
   import blde_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic signed [31:0]            req_operand_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic signed [31:0]            rsp_result_value,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count,
   output logic                          rsp_last_result
);

   localparam int KW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [KW-1:0] LAST_STEP  = KW'(DEPTH - 1);

   fsm_state_type          state_ff, state_in;
   action_type             action_ff, action_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [CW-1:0]          count_ff, count_in;
   status_type             status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
   logic [VALUE_WIDTH-1:0] feed_data;
   logic [VALUE_WIDTH-1:0] capture_data;
   logic                   delete_now;
   logic                   step;
   logic                   emit;
   logic                   full;
   logic                   empty;
   logic                   in_list;
   action_type             req_act;
   cell_ctrl_type          cell_ctrl;
   head_ctrl_type          head_ctrl;

   logic [VALUE_WIDTH+31:0] operand_wide;
   logic [VALUE_WIDTH+31:0] cell0_wide;
   logic [VALUE_WIDTH+31:0] capture_wide;

   assign operand_wide = {{VALUE_WIDTH{1'b0}}, req_operand_value};
   assign cell0_wide   = {32'b0, cell_data[0]};
   assign capture_wide = {32'b0, capture_data};

   assign req_act = action_type'(req_action);
   assign full    = count_ff == FULL_COUNT;
   assign empty   = count_ff == '0;
   assign in_list = CW'(k_ff) < count_ff;

   assign req_stall = state_ff != FSM_IDLE;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      val_in        = val_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      step          = 1'b0;
      emit          = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               action_in = req_act;
               val_in    = operand_wide[VALUE_WIDTH-1:0];
               k_in      = '0;
               status_in = STAT_OK;
               priority if (req_act == ACT_NONE) begin
                  state_in = FSM_IDLE;
               end else if ((req_act == ACT_PUSH_TAIL || req_act == ACT_PUSH_HEAD)
                            && full) begin
                  status_in = STAT_FULL;
                  state_in  = FSM_DONE;
               end else if ((req_act == ACT_POP_HEAD || req_act == ACT_POP_TAIL ||
                             req_act == ACT_REMOVE || req_act == ACT_DUMP) && empty) begin
                  status_in = STAT_EMPTY;
                  state_in  = FSM_DONE;
               end else begin
                  state_in = FSM_RUN;
               end
            end
         end
         FSM_RUN: begin
            // A dump beat can only leave when the result register is free.
            emit = (action_ff == ACT_DUMP) && in_list;
            step = !(emit && rsp_valid_ff && rsp_stall);
            if (step) begin
               k_in = k_ff + 1'b1;
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_value_in  = cell0_wide[31:0];
                  rsp_count_in  = count_ff;
                  rsp_last_in   = CW'(k_ff) == (count_ff - 1'b1);
               end
               if (k_ff == LAST_STEP) begin
                  state_in = FSM_DONE;
                  unique case (action_ff)
                     ACT_PUSH_TAIL, ACT_PUSH_HEAD: begin
                        count_in = count_ff + 1'b1;
                     end
                     ACT_POP_HEAD, ACT_POP_TAIL: begin
                        count_in = count_ff - 1'b1;
                     end
                     ACT_REMOVE: begin
                        if (delete_now) begin
                           count_in = count_ff - 1'b1;
                        end else begin
                           status_in = STAT_NOT_FOUND;
                        end
                     end
                     ACT_DUMP: begin
                        state_in = FSM_IDLE;
                     end
                     default: begin
                        count_in = count_ff;
                     end
                  endcase
               end
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = ((action_ff == ACT_POP_HEAD || action_ff == ACT_POP_TAIL)
                                && status_ff == STAT_OK) ? capture_wide[31:0] : 32'b0;
               rsp_count_in  = count_ff;
               rsp_last_in   = 1'b1;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      val_ff        <= val_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      cell_ctrl.phase = k_ff[0];
      if (!step) begin
         cell_ctrl.op = CELL_HOLD;
      end else if (action_ff == ACT_PARTITION) begin
         cell_ctrl.op = CELL_SWAP;
      end else begin
         cell_ctrl.op = CELL_ROTATE;
      end
   end

   assign head_ctrl.action = action_ff;
   assign head_ctrl.step   = step;

   blde_head #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_head (
      .clock        (clock),
      .ctrl         (head_ctrl),
      .step_index   (k_ff),
      .count        (count_ff),
      .operand      (val_ff),
      .cell0_data   (cell_data[0]),
      .cell1_data   (cell_data[1]),
      .feed_data    (feed_data),
      .delete_now   (delete_now),
      .capture_data (capture_data)
   );

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_data;
      logic [VALUE_WIDTH-1:0] right_data;

      if (gi == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_data = feed_data;
      end else begin : g_inner_right
         assign right_data = cell_data[gi+1];
      end

      blde_cell #(
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .CELL_INDEX  (gi)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[gi])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule
